// File: src/sbb_pkg.sv
// shared types, constants and codes for the sealable byte buffer
package sbb_pkg;

  localparam int unsigned LANE_BYTES      = 8;
  localparam int unsigned LANE_W          = 3;
  localparam int unsigned CNT_W           = 4;
  localparam int unsigned DATA_W          = 64;
  localparam int unsigned LEN_W           = 13;
  localparam int unsigned STORE_BYTES_DEF = 4096;
  localparam logic [LEN_W-1:0] CAP_RESET  = 13'd4096;

  typedef enum logic [2:0] {
    OP_RESET    = 3'd0,
    OP_APPEND   = 3'd1,
    OP_TRUNCATE = 3'd2,
    OP_SEAL     = 3'd3,
    OP_CANCEL   = 3'd4,
    OP_TIMEOUT  = 3'd5,
    OP_READ     = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    MODE_OPEN      = 2'd0,
    MODE_SEALED    = 2'd1,
    MODE_CANCELED  = 2'd2,
    MODE_TIMED_OUT = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FAIL = 2'd1,
    ST_END  = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [CNT_W-1:0]  byte_count;
    logic [DATA_W-1:0] write_bytes;
    logic [LEN_W-1:0]  new_length;
  } in_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [CNT_W-1:0]  read_count;
    logic [DATA_W-1:0] read_bytes;
    logic [1:0]        mode_now;
    logic [LEN_W-1:0]  fill_length;
    logic [LEN_W-1:0]  read_position;
  } out_rsp_t;

endpackage

// File: src/sbb_if.sv
// valid/ready channel interfaces for requests, results and configuration
interface sbb_in_if;
  logic             valid;
  logic             ready;
  sbb_pkg::in_req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sbb_out_if;
  logic              valid;
  logic              ready;
  sbb_pkg::out_rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sbb_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [sbb_pkg::LEN_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/sealable_byte_buffer.sv
// sealable byte buffer: linear byte store with fill length, read cursor and mode
//
// Requests arrive on in_ch (opcode, byte_count, write_bytes, new_length); each
// one yields exactly one result on out_ch (status, read bytes, mode, fill length
// and read position after the request). The buffer length limit is written on
// cfg_ch, which is always ready; write it only while no request is in flight.
// A request's result is registered and shows from the cycle after it is
// accepted. Throughput is one request per cycle while out_ch takes results;
// the store is split into eight byte banks, each with its own write and read
// port, so an unaligned eight-byte append or read touches every bank once.
// in_ch.ready is high while the result register is empty or being taken, so a
// stalled receiver holds one result and stops further requests until it drains.
// Reset (rst_n low, synchronous) empties the buffer, parks the cursor at zero,
// opens the buffer and sets the length limit to 4096. The store itself is not
// cleared; only bytes below the fill length are ever read.
module sealable_byte_buffer #(
  parameter int unsigned STORE_BYTES = sbb_pkg::STORE_BYTES_DEF
) (
  input logic       clk,
  input logic       rst_n,
  sbb_cfg_if.sink   cfg_ch,
  sbb_in_if.sink    in_ch,
  sbb_out_if.source out_ch
);

  localparam int unsigned ROWS  = (STORE_BYTES + sbb_pkg::LANE_BYTES - 1) /
                                  sbb_pkg::LANE_BYTES;
  localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  // state, which doubles as the result register for mode, length and cursor
  logic [sbb_pkg::LEN_W-1:0]  cap_r;
  logic [sbb_pkg::LEN_W-1:0]  held_r, held_nxt;
  logic [sbb_pkg::LEN_W-1:0]  cur_r, cur_nxt;
  sbb_pkg::mode_t             mode_r, mode_nxt;
  sbb_pkg::status_t           st_r, st_nxt;
  logic [sbb_pkg::CNT_W-1:0]  rcnt_r, rcnt_nxt;
  logic [sbb_pkg::LANE_W-1:0] roff_r;
  logic                       out_valid_r;

  logic                       accept;
  logic                       app_ok;
  logic [sbb_pkg::LEN_W-1:0]  eff_cap;
  logic [sbb_pkg::LEN_W-1:0]  room;
  logic [sbb_pkg::LEN_W-1:0]  remaining;
  logic [sbb_pkg::CNT_W-1:0]  limit;
  logic [sbb_pkg::CNT_W-1:0]  got;
  logic [sbb_pkg::LEN_W-1:0]  wr_row_base;
  logic [sbb_pkg::LEN_W-1:0]  rd_row_base;
  logic [sbb_pkg::DATA_W-1:0] wr_rot;
  logic [sbb_pkg::DATA_W-1:0] bank_q;
  logic [sbb_pkg::DATA_W-1:0] rd_rot;
  logic [sbb_pkg::DATA_W-1:0] rd_data;
  logic                       rd_en;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= sbb_pkg::CAP_RESET;
    end else if (cfg_ch.valid) begin
      cap_r <= cfg_ch.data;
    end
  end

  // limits above the store size act as the store size
  assign eff_cap = (32'(cap_r) > STORE_BYTES) ? sbb_pkg::LEN_W'(STORE_BYTES) : cap_r;
  assign room    = (eff_cap > held_r) ? (eff_cap - held_r) : '0;

  assign remaining = held_r - cur_r;
  assign limit     = (in_ch.data.byte_count > sbb_pkg::CNT_W'(sbb_pkg::LANE_BYTES)) ?
                     sbb_pkg::CNT_W'(sbb_pkg::LANE_BYTES) : in_ch.data.byte_count;
  assign got       = (remaining < sbb_pkg::LEN_W'(limit)) ?
                     sbb_pkg::CNT_W'(remaining) : limit;

  always_comb begin
    held_nxt = held_r;
    cur_nxt  = cur_r;
    mode_nxt = mode_r;
    st_nxt   = sbb_pkg::ST_FAIL;
    rcnt_nxt = '0;
    app_ok   = 1'b0;
    unique case (in_ch.data.opcode)
      sbb_pkg::OP_RESET: begin
        held_nxt = '0;
        cur_nxt  = '0;
        mode_nxt = sbb_pkg::MODE_OPEN;
        st_nxt   = sbb_pkg::ST_OK;
      end
      sbb_pkg::OP_APPEND: begin
        if (mode_r == sbb_pkg::MODE_OPEN &&
            in_ch.data.byte_count <= sbb_pkg::CNT_W'(sbb_pkg::LANE_BYTES) &&
            sbb_pkg::LEN_W'(in_ch.data.byte_count) <= room) begin
          app_ok   = 1'b1;
          held_nxt = held_r + sbb_pkg::LEN_W'(in_ch.data.byte_count);
          st_nxt   = sbb_pkg::ST_OK;
        end
      end
      sbb_pkg::OP_TRUNCATE: begin
        if (in_ch.data.new_length <= held_r && cur_r <= in_ch.data.new_length &&
            (mode_r == sbb_pkg::MODE_OPEN || mode_r == sbb_pkg::MODE_SEALED)) begin
          held_nxt = in_ch.data.new_length;
          st_nxt   = sbb_pkg::ST_OK;
        end
      end
      sbb_pkg::OP_SEAL: begin
        if (mode_r == sbb_pkg::MODE_OPEN) begin
          mode_nxt = sbb_pkg::MODE_SEALED;
          st_nxt   = sbb_pkg::ST_OK;
        end
      end
      sbb_pkg::OP_CANCEL: begin
        mode_nxt = sbb_pkg::MODE_CANCELED;
        st_nxt   = sbb_pkg::ST_OK;
      end
      sbb_pkg::OP_TIMEOUT: begin
        mode_nxt = sbb_pkg::MODE_TIMED_OUT;
        st_nxt   = sbb_pkg::ST_OK;
      end
      sbb_pkg::OP_READ: begin
        priority if (mode_r == sbb_pkg::MODE_CANCELED ||
                     mode_r == sbb_pkg::MODE_TIMED_OUT) begin
          st_nxt = sbb_pkg::ST_FAIL;
        end else if (cur_r >= held_r) begin
          st_nxt = (mode_r == sbb_pkg::MODE_SEALED) ? sbb_pkg::ST_END : sbb_pkg::ST_OK;
        end else begin
          st_nxt   = sbb_pkg::ST_OK;
          rcnt_nxt = got;
          cur_nxt  = cur_r + sbb_pkg::LEN_W'(got);
        end
      end
      default: begin
        st_nxt = sbb_pkg::ST_FAIL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      cur_r       <= '0;
      mode_r      <= sbb_pkg::MODE_OPEN;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        held_r      <= held_nxt;
        cur_r       <= cur_nxt;
        mode_r      <= mode_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_r   <= st_nxt;
      rcnt_r <= rcnt_nxt;
      roff_r <= cur_r[sbb_pkg::LANE_W-1:0];
    end
  end

  // banks hold byte addresses congruent to their index; lanes rotate by the offset
  assign wr_row_base = held_r >> sbb_pkg::LANE_W;
  assign rd_row_base = cur_r >> sbb_pkg::LANE_W;
  assign rd_en       = accept && (in_ch.data.opcode == sbb_pkg::OP_READ);

  always_comb begin
    logic [2*sbb_pkg::DATA_W-1:0] wide;
    wide   = {in_ch.data.write_bytes, in_ch.data.write_bytes} <<
             {held_r[sbb_pkg::LANE_W-1:0], 3'b000};
    wr_rot = wide[2*sbb_pkg::DATA_W-1:sbb_pkg::DATA_W];
  end

  for (genvar b = 0; b < sbb_pkg::LANE_BYTES; b++) begin : g_bank
    logic [sbb_pkg::LANE_W-1:0] lane;
    logic                       wr_en;
    logic [ROW_W-1:0]           wr_row;
    logic [ROW_W-1:0]           rd_row;

    assign lane   = sbb_pkg::LANE_W'(b) - held_r[sbb_pkg::LANE_W-1:0];
    assign wr_en  = accept && app_ok &&
                    ({1'b0, lane} < in_ch.data.byte_count);
    assign wr_row = ROW_W'(wr_row_base + sbb_pkg::LEN_W'(
                    sbb_pkg::LANE_W'(b) < held_r[sbb_pkg::LANE_W-1:0]));
    assign rd_row = ROW_W'(rd_row_base + sbb_pkg::LEN_W'(
                    sbb_pkg::LANE_W'(b) < cur_r[sbb_pkg::LANE_W-1:0]));

    sbb_bank #(
      .ROWS  (ROWS),
      .ROW_W (ROW_W)
    ) u_bank (
      .clk       (clk),
      .wr_en     (wr_en),
      .wr_row    (wr_row),
      .wr_byte   (wr_rot[8*b +: 8]),
      .rd_en     (rd_en),
      .rd_row    (rd_row),
      .rd_byte_r (bank_q[8*b +: 8])
    );
  end

  always_comb begin
    logic [2*sbb_pkg::DATA_W-1:0] wide;
    wide   = {bank_q, bank_q} >> {roff_r, 3'b000};
    rd_rot = wide[sbb_pkg::DATA_W-1:0];
    for (int i = 0; i < sbb_pkg::LANE_BYTES; i++) begin
      rd_data[8*i +: 8] = (sbb_pkg::CNT_W'(i) < rcnt_r) ? rd_rot[8*i +: 8] : 8'h00;
    end
  end

  assign out_ch.valid = out_valid_r;

  always_comb begin
    out_ch.data.status        = st_r;
    out_ch.data.read_count    = rcnt_r;
    out_ch.data.read_bytes    = rd_data;
    out_ch.data.mode_now      = mode_r;
    out_ch.data.fill_length   = held_r;
    out_ch.data.read_position = cur_r;
  end

  // the cursor never passes the fill length
  a_cursor_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r <= held_r)
    else $error("read cursor beyond fill length");

  // the fill never exceeds the store
  a_fill_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    32'(held_r) <= STORE_BYTES)
    else $error("fill length beyond store size");

  // end of data is only reported on a drained sealed buffer
  a_end_sealed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && st_r == sbb_pkg::ST_END) |->
      (mode_r == sbb_pkg::MODE_SEALED && rcnt_r == '0 && cur_r == held_r))
    else $error("end status outside drained sealed buffer");

  // a read that returns bytes moves the cursor by exactly that many
  a_cursor_step: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.data.opcode == sbb_pkg::OP_READ) |=>
      (cur_r == $past(cur_r) + sbb_pkg::LEN_W'(rcnt_r)))
    else $error("cursor step differs from read count");

endmodule

// File: src/sbb_bank.sv
// one byte bank of the store: one write port, one registered read port
module sbb_bank #(
  parameter int unsigned ROWS  = 512,
  parameter int unsigned ROW_W = 9
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [ROW_W-1:0] wr_row,
  input  logic [7:0]       wr_byte,
  input  logic             rd_en,
  input  logic [ROW_W-1:0] rd_row,
  output logic [7:0]       rd_byte_r
);

  logic [7:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= wr_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_byte_r <= mem[rd_row];
    end
  end

endmodule
